>>> hdl/css_pkg.sv
package css_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int COORD_WIDTH_DEF  = 16;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	localparam int DIAMETER_RST = 1024;
	localparam int DIST_MARGIN_RST = 26;
	localparam int HEAD_MARGIN_RST = 5;
	localparam int TURN_RATE_RST = 60;
	localparam int DRIVE_RATE_RST = 205;

	localparam int SQ_W   = 17;
	localparam int PROD_W = 2 * SQ_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int CMP_W  = ACC_W + 2;

	localparam int XW       = 64;
	localparam int ZW       = 24;
	localparam int PRESCALE = 58;
	localparam int PI_Q16   = 205887;
	localparam int PI_Q13   = 25736;

	localparam int MARGIN_MUL = 9371420;
	localparam int MARGIN_RND = 32768;
	localparam int TURN_MAX   = 180;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CIRCLE_DIAMETER = 3'd0,
		REG_DISTANCE_MARGIN = 3'd1,
		REG_HEADING_MARGIN  = 3'd2,
		REG_TURN_RATE       = 3'd3,
		REG_DRIVE_RATE      = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ZONE_INSIDE  = 2'd0,
		ZONE_OUTSIDE = 2'd1,
		ZONE_ON      = 2'd2
	} zone_t;

	typedef enum logic [2:0] {
		STEP_WAIT   = 3'd0,
		STEP_DIFF   = 3'd1,
		STEP_SQ_X   = 3'd2,
		STEP_SQ_Y   = 3'd3,
		STEP_SQ_LO  = 3'd4,
		STEP_SQ_HI  = 3'd5,
		STEP_CORDIC = 3'd6,
		STEP_DECIDE = 3'd7
	} step_t;

	typedef enum logic [2:0] {
		MUL_HOLD = 3'd0,
		MUL_AX   = 3'd1,
		MUL_AY   = 3'd2,
		MUL_LO   = 3'd3,
		MUL_HI   = 3'd4
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2
	} acc_op_t;

	typedef enum logic [2:0] {
		JMP_NONE      = 3'd0,
		JMP_IN_IDLE   = 3'd1,
		JMP_NO_TARGET = 3'd2,
		JMP_LOOP      = 3'd3,
		JMP_OUT_BUSY  = 3'd4
	} jmp_t;

	typedef struct packed {
		logic     wait_in;
		logic     ld_diff;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     ld_lo2;
		logic     ld_hi2;
		logic     cordic_step;
		logic     decide;
		jmp_t     jmp;
		step_t    target;
		logic     last;
	} ctrl_t;

	typedef struct packed {
		logic no_target;
		logic out_busy;
	} status_t;

	function automatic logic [16:0] atan_q16(input logic [4:0] idx);
		logic [16:0] r;
		case (idx)
			5'd0: r = 17'd51472;
			5'd1: r = 17'd30386;
			5'd2: r = 17'd16055;
			5'd3: r = 17'd8150;
			5'd4: r = 17'd4091;
			5'd5: r = 17'd2047;
			5'd6: r = 17'd1024;
			5'd7: r = 17'd512;
			5'd8: r = 17'd256;
			5'd9: r = 17'd128;
			5'd10: r = 17'd64;
			5'd11: r = 17'd32;
			5'd12: r = 17'd16;
			5'd13: r = 17'd8;
			5'd14: r = 17'd4;
			5'd15: r = 17'd2;
			5'd16: r = 17'd1;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/css_seq.sv
module css_seq #(
	parameter int CORDIC_STEPS = css_pkg::CORDIC_STEPS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  css_pkg::status_t  status,
	output css_pkg::ctrl_t    ctrl,
	output logic [$clog2(CORDIC_STEPS)-1:0] iter
);
	import css_pkg::*;

	localparam int IW = $clog2(CORDIC_STEPS);
	localparam logic [IW-1:0] LAST_ITER = IW'(CORDIC_STEPS - 1);

	step_t          pc_q;
	step_t          pc_d;
	logic [IW-1:0]  iter_q;
	logic           take;

	function automatic ctrl_t rom(input step_t s);
		ctrl_t c;
		c = '0;
		case (s)
			STEP_WAIT: begin
				c.wait_in = 1'b1;
				c.jmp = JMP_IN_IDLE;
				c.target = STEP_WAIT;
			end
			STEP_DIFF: begin
				c.ld_diff = 1'b1;
				c.jmp = JMP_NO_TARGET;
				c.target = STEP_DECIDE;
			end
			STEP_SQ_X: begin
				c.mul_sel = MUL_AX;
			end
			STEP_SQ_Y: begin
				c.mul_sel = MUL_AY;
				c.acc_op = ACC_LOAD;
			end
			STEP_SQ_LO: begin
				c.mul_sel = MUL_LO;
				c.acc_op = ACC_ADD;
			end
			STEP_SQ_HI: begin
				c.mul_sel = MUL_HI;
				c.ld_lo2 = 1'b1;
			end
			STEP_CORDIC: begin
				c.ld_hi2 = 1'b1;
				c.cordic_step = 1'b1;
				c.jmp = JMP_LOOP;
				c.target = STEP_CORDIC;
			end
			STEP_DECIDE: begin
				c.decide = 1'b1;
				c.jmp = JMP_OUT_BUSY;
				c.target = STEP_DECIDE;
				c.last = 1'b1;
			end
			default: begin
				c.last = 1'b1;
			end
		endcase
		return c;
	endfunction

	assign ctrl = rom(pc_q);
	assign iter = iter_q;

	always_comb begin
		case (ctrl.jmp)
			JMP_IN_IDLE:   take = !in_valid;
			JMP_NO_TARGET: take = status.no_target;
			JMP_LOOP:      take = (iter_q != LAST_ITER);
			JMP_OUT_BUSY:  take = status.out_busy;
			default:       take = 1'b0;
		endcase
		if (take) begin
			pc_d = ctrl.target;
		end else if (ctrl.last) begin
			pc_d = STEP_WAIT;
		end else begin
			pc_d = step_t'(3'(pc_q + 3'd1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_WAIT;
			iter_q <= '0;
		end else begin
			pc_q <= pc_d;
			if (ctrl.cordic_step) begin
				iter_q <= (iter_q == LAST_ITER) ? '0 : IW'(iter_q + 1'b1);
			end
		end
	end

	a_accept_to_diff: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && ctrl.wait_in) |=> (pc_q == STEP_DIFF))
		else $error("accepted beat did not advance to difference step");

	a_iter_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!ctrl.cordic_step |-> (iter_q == '0))
		else $error("iteration counter not cleared outside loop");

	a_loop_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == STEP_CORDIC && iter_q != LAST_ITER) |=> (pc_q == STEP_CORDIC))
		else $error("rotation loop left early");

endmodule

>>> hdl/css_dp.sv
module css_dp #(
	parameter int CORDIC_STEPS = css_pkg::CORDIC_STEPS_DEF,
	parameter int COORD_WIDTH  = css_pkg::COORD_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [css_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [css_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	input  logic signed [COORD_WIDTH-1:0]   robot_x,
	input  logic signed [COORD_WIDTH-1:0]   robot_y,
	input  logic signed [15:0]              robot_heading,
	input  logic                            target_seen,
	input  logic signed [COORD_WIDTH-1:0]   sighted_x,
	input  logic signed [COORD_WIDTH-1:0]   sighted_y,
	input  css_pkg::ctrl_t                  ctrl,
	input  logic [$clog2(CORDIC_STEPS)-1:0] iter,
	output css_pkg::status_t                status,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic                            command_valid,
	output logic signed [10:0]              drive_cmd,
	output logic signed [8:0]               turn_cmd,
	output logic [1:0]                      zone
);
	import css_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int AW = (CW + 1 > SQ_W + 1) ? CW + 1 : SQ_W + 1;
	localparam logic [SQ_W-1:0] SQ_MAX = '1;

	// configuration
	logic [15:0] diameter_q;
	logic [11:0] dist_margin_q;
	logic [6:0]  head_margin_q;
	logic [7:0]  turn_rate_q;
	logic [9:0]  drive_rate_q;

	// latched item and target
	logic signed [CW-1:0] known_x_q, known_y_q;
	logic                 target_known_q;
	logic signed [CW-1:0] rx_q, ry_q;
	logic signed [15:0]   yaw_q;

	logic [SQ_W-1:0]      ax_q, ay_q;
	logic                 nz_q;
	logic [PROD_W-1:0]    prod_q, lo2_q, hi2_q;
	logic [ACC_W-1:0]     acc_q;
	logic signed [XW-1:0] x_q, y_q;
	logic signed [ZW-1:0] z_q;

	logic                 out_valid_q, cmd_valid_q;
	logic signed [10:0]   fwd_q;
	logic signed [8:0]    trn_q;
	zone_t                zone_q;

	logic                 in_fire, out_busy, load_out;
	logic signed [CW:0]   dx, dy;
	logic signed [XW-1:0] xi, yi, xs, ys;
	logic signed [ZW-1:0] at;
	logic signed [17:0]   lo;
	logic                 lo_pos;
	logic [SQ_W-1:0]      hi;
	logic [SQ_W-1:0]      mul_a;
	logic [CMP_W-1:0]     d4;
	logic                 is_inside, is_outside;
	zone_t                zone_d;
	logic signed [ZW-1:0] zr, zb, zc;
	logic signed [15:0]   bear;
	logic [30:0]          mprod;
	logic signed [17:0]   yaw_e, b_e, m_e;
	logic [7:0]           tr;
	logic signed [8:0]    trn_d;
	logic signed [10:0]   fwd_d;

	function automatic logic [SQ_W-1:0] sat_abs(input logic signed [CW:0] d);
		logic [CW:0]   mag;
		logic [AW-1:0] ext;
		mag = d[CW] ? (CW+1)'(-d) : d;
		ext = AW'(mag);
		return (ext > AW'(SQ_MAX)) ? SQ_MAX : ext[SQ_W-1:0];
	endfunction

	assign in_fire  = in_valid && ctrl.wait_in;
	assign out_busy = out_valid_q && !out_ready;
	assign load_out = ctrl.decide && !out_busy;
	assign status   = '{no_target: !target_known_q, out_busy: out_busy};

	assign dx = {known_x_q[CW-1], known_x_q} - {rx_q[CW-1], rx_q};
	assign dy = {known_y_q[CW-1], known_y_q} - {ry_q[CW-1], ry_q};
	assign xi = XW'(dx) <<< (PRESCALE - CW);
	assign yi = XW'(dy) <<< (PRESCALE - CW);

	assign xs = x_q >>> iter;
	assign ys = y_q >>> iter;
	assign at = ZW'(atan_q16(5'(iter)));

	assign lo     = 18'(diameter_q) - 18'({dist_margin_q, 1'b0});
	assign lo_pos = !lo[17] && (lo != '0);
	assign hi     = SQ_W'(diameter_q) + SQ_W'({dist_margin_q, 1'b0});

	always_comb begin
		case (ctrl.mul_sel)
			MUL_AX:  mul_a = ax_q;
			MUL_AY:  mul_a = ay_q;
			MUL_LO:  mul_a = lo[SQ_W-1:0];
			MUL_HI:  mul_a = hi;
			default: mul_a = '0;
		endcase
	end

	// zone from squared distance
	assign d4         = {acc_q, 2'b00};
	assign is_inside  = lo_pos && (d4 < CMP_W'(lo2_q));
	assign is_outside = d4 > CMP_W'(hi2_q);

	always_comb begin
		if (is_inside) begin
			zone_d = ZONE_INSIDE;
		end else if (is_outside) begin
			zone_d = ZONE_OUTSIDE;
		end else begin
			zone_d = ZONE_ON;
		end
	end

	// bearing and heading window
	assign zr = z_q + ZW'(4);
	assign zb = zr >>> 3;
	always_comb begin
		if (zb > ZW'(PI_Q13)) begin
			zc = ZW'(PI_Q13);
		end else if (zb < -ZW'(PI_Q13)) begin
			zc = -ZW'(PI_Q13);
		end else begin
			zc = zb;
		end
	end
	assign bear  = 16'(zc);
	assign mprod = 31'(head_margin_q) * 31'(MARGIN_MUL) + 31'(MARGIN_RND);
	assign yaw_e = 18'(yaw_q);
	assign b_e   = 18'(bear);
	assign m_e   = 18'(mprod[30:16]);
	assign tr    = (turn_rate_q > 8'(TURN_MAX)) ? 8'(TURN_MAX) : turn_rate_q;

	always_comb begin
		trn_d = '0;
		if (nz_q && (yaw_e > b_e + m_e)) begin
			trn_d = -9'(tr);
		end else if (nz_q && (yaw_e < b_e - m_e)) begin
			trn_d = 9'(tr);
		end
		fwd_d = '0;
		if (trn_d == '0) begin
			case (zone_d)
				ZONE_INSIDE:  fwd_d = -11'(drive_rate_q);
				ZONE_OUTSIDE: fwd_d = 11'(drive_rate_q);
				default:      fwd_d = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diameter_q <= 16'(DIAMETER_RST);
			dist_margin_q <= 12'(DIST_MARGIN_RST);
			head_margin_q <= 7'(HEAD_MARGIN_RST);
			turn_rate_q <= 8'(TURN_RATE_RST);
			drive_rate_q <= 10'(DRIVE_RATE_RST);
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_CIRCLE_DIAMETER: diameter_q <= cfg_data;
				REG_DISTANCE_MARGIN: dist_margin_q <= cfg_data[11:0];
				REG_HEADING_MARGIN:  head_margin_q <= cfg_data[6:0];
				REG_TURN_RATE:       turn_rate_q <= cfg_data[7:0];
				REG_DRIVE_RATE:      drive_rate_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_x_q <= '0;
			known_y_q <= '0;
			target_known_q <= 1'b0;
		end else if (in_fire && target_seen) begin
			known_x_q <= sighted_x;
			known_y_q <= sighted_y;
			target_known_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rx_q <= robot_x;
			ry_q <= robot_y;
			yaw_q <= robot_heading;
		end
		if (ctrl.ld_diff) begin
			ax_q <= sat_abs(dx);
			ay_q <= sat_abs(dy);
			nz_q <= (dx != '0) || (dy != '0);
			if (dx[CW]) begin
				x_q <= -xi;
				y_q <= -yi;
				z_q <= dy[CW] ? -ZW'(PI_Q16) : ZW'(PI_Q16);
			end else begin
				x_q <= xi;
				y_q <= yi;
				z_q <= '0;
			end
		end else if (ctrl.cordic_step) begin
			if (!y_q[XW-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
		if (ctrl.mul_sel != MUL_HOLD) begin
			prod_q <= mul_a * mul_a;
		end
		case (ctrl.acc_op)
			ACC_LOAD: acc_q <= ACC_W'(prod_q);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
			default: ;
		endcase
		if (ctrl.ld_lo2) begin
			lo2_q <= prod_q;
		end
		if (ctrl.ld_hi2) begin
			hi2_q <= prod_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			cmd_valid_q <= target_known_q;
			if (target_known_q) begin
				fwd_q <= fwd_d;
				trn_q <= trn_d;
				zone_q <= zone_d;
			end else begin
				fwd_q <= '0;
				trn_q <= '0;
				zone_q <= ZONE_INSIDE;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign command_valid = cmd_valid_q;
	assign drive_cmd     = fwd_q;
	assign turn_cmd      = trn_q;
	assign zone          = zone_q;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !cmd_valid_q) |-> (fwd_q == '0 && trn_q == '0 && zone_q == ZONE_INSIDE))
		else $error("command without target is not zero");

	a_turn_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && trn_q != '0) |-> (fwd_q == '0))
		else $error("drive ordered while turning");

	a_decide_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.decide && !out_busy) |=> out_valid_q)
		else $error("decision step did not fill result register");

endmodule

>>> hdl/circle_surround_steering_unit.sv
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------------
// in       | in_valid / in_ready  | robot_x, robot_y, robot_heading, target_seen,
//          |                      | sighted_x, sighted_y
// out      | out_valid/ out_ready | command_valid, drive_cmd, turn_cmd, zone
// cfg      | cfg_write            | cfg_index, cfg_data
//
// one beat runs from accept through the difference step, the squarer steps, the rotation loop
// of the microcode sequencer and the decision step, with one shared squarer
// a beat with no target known yet jumps from the difference step to the decision step
// the result register lets the next beat be accepted while a result waits
// the decision step holds while the result register is still full
// arst_n clears the step counter, target latch and result valid and loads the configuration defaults
module circle_surround_steering_unit #(
	parameter int CORDIC_STEPS = css_pkg::CORDIC_STEPS_DEF,
	parameter int COORD_WIDTH  = css_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [css_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [css_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] robot_x,
	input  logic signed [COORD_WIDTH-1:0] robot_y,
	input  logic signed [15:0]            robot_heading,
	input  logic                          target_seen,
	input  logic signed [COORD_WIDTH-1:0] sighted_x,
	input  logic signed [COORD_WIDTH-1:0] sighted_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          command_valid,
	output logic signed [10:0]            drive_cmd,
	output logic signed [8:0]             turn_cmd,
	output logic [1:0]                    zone
);
	import css_pkg::*;

	ctrl_t                          ctrl;
	status_t                        status;
	logic [$clog2(CORDIC_STEPS)-1:0] iter;

	assign in_ready = ctrl.wait_in;

	css_seq #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.ctrl     (ctrl),
		.iter     (iter)
	);

	css_dp #(
		.CORDIC_STEPS(CORDIC_STEPS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.robot_x       (robot_x),
		.robot_y       (robot_y),
		.robot_heading (robot_heading),
		.target_seen   (target_seen),
		.sighted_x     (sighted_x),
		.sighted_y     (sighted_y),
		.ctrl          (ctrl),
		.iter          (iter),
		.status        (status),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.command_valid (command_valid),
		.drive_cmd     (drive_cmd),
		.turn_cmd      (turn_cmd),
		.zone          (zone)
	);

endmodule
